>>> src/hte_pkg.sv
// ----------------------------------------------------------------------------
// hte_pkg
// Shared types and constants for the table-driven Huffman encoder and packer.
// ----------------------------------------------------------------------------
package hte_pkg;

	// Parameter defaults
	localparam int MAX_CODE_LEN_DEF = 16;
	localparam int SYMBOL_COUNT_DEF = 256;

	// Field widths
	localparam int CMD_W  = 2;
	localparam int SYM_W  = 8;
	localparam int CODE_W = 16;
	localparam int LEN_W  = 5;
	localparam int BYTE_W = 8;
	localparam int PEND_W = 7;   // at most 7 bits wait between bytes
	localparam int PCNT_W = 3;

	// Output buffer bytes; one encode completes at most 2 (7 pending + 16 code bits)
	localparam int MAX_BYTES = 3;
	localparam int BCNT_W    = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	// Code store write request
	typedef struct packed {
		logic              en;
		logic [SYM_W-1:0]  addr;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} hte_wr_t;

	// Code store read result
	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} hte_rd_t;

endpackage

>>> src/huffman_table_encoder_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_table_encoder_bit_packer_unit
// Table-driven Huffman encoder: loads code words, packs encoded symbols MSB
// first into bytes, and pads the tail on flush.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                   | tuser      | tlast
//  --------+-----+-----------------------------------------+------------+------------
//  s_      | in  | symbol[7:0] code_value[23:8] length[28:24] | command  | -
//  m_      | out | out_byte[7:0]                           | end_of_str | last_of_run
//
//  Flow: one transaction per cycle enters the table lookup while s_tready
//  is high; loads write the table when accepted. An encode or flush that
//  completes bytes holds the 3-byte output buffer until its last byte
//  pops, so the output port (one byte per cycle while m_tready is high)
//  sets the sustained rate. Path: registered store read, then output buffer.
//  Reset: valid bits of the code table clear at once; no clearing pass.
//  Stalls: m_tready low holds the buffer; s_tready drops only when the
//  lookup stage holds an item with bytes and the buffer neither is empty nor pops its last byte.
//
module huffman_table_encoder_bit_packer_unit #(
	parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF,
	parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // symbol[7:0], code_value[23:8], code_length[28:24]
	input  logic [1:0]  s_tuser,   // command[1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast,   // last_of_run
	output logic        m_tuser    // end_of_stream[0]
);

	localparam int LEN_BITS = $clog2(MAX_CODE_LEN + 1);
	localparam int ACC_W    = hte_pkg::PEND_W + MAX_CODE_LEN;
	localparam int TOT_W    = $clog2(ACC_W + 1);
	localparam int SH_W     = TOT_W + 2;
	localparam logic [hte_pkg::SYM_W:0]   SYM_LIM = (hte_pkg::SYM_W + 1)'(SYMBOL_COUNT);
	localparam logic [hte_pkg::LEN_W-1:0] LEN_MAX = hte_pkg::LEN_W'(MAX_CODE_LEN);

	// input fields
	hte_pkg::cmd_t                 in_cmd;
	logic [hte_pkg::SYM_W-1:0]     in_sym;
	logic [hte_pkg::CODE_W-1:0]    in_code;
	logic [hte_pkg::LEN_W-1:0]     in_len;
	logic                          in_range;
	logic                          accept;

	assign in_cmd   = hte_pkg::cmd_t'(s_tuser);
	assign in_sym   = s_tdata[7:0];
	assign in_code  = s_tdata[23:8];
	assign in_len   = s_tdata[28:24];
	assign in_range = {1'b0, in_sym} < SYM_LIM;
	assign accept   = s_tvalid & s_tready;

	// code table: written on an accepted in-range load, read at every accept
	hte_pkg::hte_wr_t wr;
	hte_pkg::hte_rd_t rd;

	always_comb begin
		wr.en   = accept && (in_cmd == hte_pkg::CMD_LOAD) && in_range;
		wr.addr = in_sym;
		wr.code = in_code;
		wr.len  = (in_len > LEN_MAX) ? LEN_MAX : in_len;
	end

	hte_code_store #(
		.SYMBOL_COUNT (SYMBOL_COUNT),
		.LEN_BITS     (LEN_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_en   (accept),
		.rd_addr (in_sym),
		.rd      (rd)
	);

	// lookup stage
	logic          vld_s1;
	hte_pkg::cmd_t cmd_s1;
	logic          range_s1;

	// packer state
	logic [hte_pkg::PEND_W-1:0] pend_bits_q;
	logic [hte_pkg::PCNT_W-1:0] pend_cnt_q;

	// output buffer
	logic [hte_pkg::BYTE_W-1:0] obuf_q [hte_pkg::MAX_BYTES];
	logic [hte_pkg::BCNT_W-1:0] ob_cnt_q;
	logic                       eos_q;

	// packing datapath
	logic [hte_pkg::LEN_W-1:0]  len_eff;
	logic [ACC_W-1:0]           acc;
	logic [ACC_W-1:0]           code_msk;
	logic [TOT_W-1:0]           total;
	logic [SH_W-1:0]            sh;
	logic [hte_pkg::BYTE_W-1:0] bytes [hte_pkg::MAX_BYTES];
	logic [hte_pkg::BYTE_W-1:0] flush_byte;
	logic [hte_pkg::BCNT_W-1:0] n_s1;
	logic                       is_enc;
	logic                       is_flush;
	logic                       ob_free;
	logic                       adv;

	assign is_enc   = vld_s1 && (cmd_s1 == hte_pkg::CMD_ENCODE);
	assign is_flush = vld_s1 && (cmd_s1 == hte_pkg::CMD_FLUSH);

	always_comb begin
		len_eff  = (range_s1 && rd.hit) ? rd.len : '0;
		code_msk = ACC_W'(rd.code) & ~({ACC_W{1'b1}} << len_eff);
		acc      = (ACC_W'(pend_bits_q) << len_eff) | code_msk;
		total    = TOT_W'(pend_cnt_q) + TOT_W'(len_eff);
		for (int k = 0; k < hte_pkg::MAX_BYTES; k++) begin
			// MSB-first: byte k sits just below the k*8 bits already taken
			sh       = SH_W'(total) - SH_W'(hte_pkg::BYTE_W * (k + 1));
			bytes[k] = hte_pkg::BYTE_W'(acc >> sh);
		end
		// pending bits left-justified, zero padded
		flush_byte = {pend_bits_q, 1'b0} << (hte_pkg::PCNT_W'(7) - pend_cnt_q);
		case (cmd_s1)
			hte_pkg::CMD_ENCODE: n_s1 = hte_pkg::BCNT_W'(total >> 3);
			hte_pkg::CMD_FLUSH:  n_s1 = hte_pkg::BCNT_W'(1);
			default:             n_s1 = '0;
		endcase
	end

	// buffer empties by the next edge
	assign ob_free  = (ob_cnt_q == '0) || ((ob_cnt_q == hte_pkg::BCNT_W'(1)) && m_tready);
	assign adv      = vld_s1 && ((n_s1 == '0) || ob_free);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= in_cmd;
			range_s1 <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv && is_enc) begin
				pend_cnt_q  <= total[hte_pkg::PCNT_W-1:0];
				pend_bits_q <= acc[hte_pkg::PEND_W-1:0]
					& ~({hte_pkg::PEND_W{1'b1}} << total[hte_pkg::PCNT_W-1:0]);
			end else if (adv && is_flush) begin
				pend_cnt_q  <= '0;
				pend_bits_q <= '0;
			end
		end
	end

	// buffer payload: load when the stage hands over bytes, else shift on pop
	always_ff @(posedge clk) begin
		if (adv && (n_s1 != '0)) begin
			if (is_flush) begin
				obuf_q[0] <= flush_byte;
			end else begin
				for (int k = 0; k < hte_pkg::MAX_BYTES; k++) begin
					obuf_q[k] <= bytes[k];
				end
			end
			eos_q <= is_flush;
		end else if (m_tvalid && m_tready) begin
			for (int k = 0; k < hte_pkg::MAX_BYTES - 1; k++) begin
				obuf_q[k] <= obuf_q[k + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= '0;
		end else if (adv && (n_s1 != '0)) begin
			ob_cnt_q <= n_s1;
		end else if (m_tvalid && m_tready) begin
			ob_cnt_q <= ob_cnt_q - hte_pkg::BCNT_W'(1);
		end
	end

	assign m_tvalid = (ob_cnt_q != '0);
	assign m_tdata  = obuf_q[0];
	assign m_tlast  = (ob_cnt_q == hte_pkg::BCNT_W'(1));
	assign m_tuser  = eos_q;

endmodule

>>> src/hte_code_store.sv
// ----------------------------------------------------------------------------
// hte_code_store
// Code table memory, one write and one registered read port, with per-entry
// valid bits so that a never-loaded entry reads with hit clear.
// ----------------------------------------------------------------------------
module hte_code_store #(
	parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF,
	parameter int LEN_BITS     = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hte_pkg::hte_wr_t        wr,
	input  logic                    rd_en,
	input  logic [hte_pkg::SYM_W-1:0] rd_addr,
	output hte_pkg::hte_rd_t        rd
);

	localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int EW = hte_pkg::CODE_W + LEN_BITS;

	logic [EW-1:0]           mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] vld_q;
	logic [EW-1:0]           rdata_q;
	logic                    rhit_q;

	logic [AW-1:0] wa;
	logic [AW-1:0] ra;

	assign wa = wr.addr[AW-1:0];
	assign ra = rd_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wa] <= {wr.code, wr.len[LEN_BITS-1:0]};
		end
		if (rd_en) begin
			rdata_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rhit_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wa] <= 1'b1;
			end
			if (rd_en) begin
				rhit_q <= vld_q[ra];
			end
		end
	end

	assign rd.hit  = rhit_q;
	assign rd.code = rdata_q[EW-1:LEN_BITS];
	assign rd.len  = hte_pkg::LEN_W'(rdata_q[LEN_BITS-1:0]);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Huffman table encoder and bit packer. A short
// table of directed transactions (empty flush, absent symbols, longest codes,
// length saturation, stray code bits, unused command) is followed by random
// load/encode/flush traffic. Every byte is checked against its typed row or
// a code table and accumulator model, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [hte_pkg::LEN_W-1:0] LEN_CAP = hte_pkg::LEN_W'(hte_pkg::MAX_CODE_LEN_DEF);
	localparam int BY_MODEL  = -1;    // row checked by the model, not typed
	localparam int DIR_N     = 25;
	localparam int RAND_N    = 300;
	localparam int SEED_N    = 24;    // first random transactions fill the table
	localparam int CALM_N    = 60;    // tail of the run with no idling
	localparam int HOLD_CYC  = 80;    // long receiver hold-off
	localparam int DRAIN_CYC = 16;
	localparam int CYC_LIMIT = 60000;

	typedef struct packed {
		logic [1:0]                 cmd;
		logic [hte_pkg::SYM_W-1:0]  sym;
		logic [hte_pkg::CODE_W-1:0] code;
		logic [hte_pkg::LEN_W-1:0]  len;
		int                         n_typed;   // BY_MODEL or number of typed bytes
		logic [7:0]                 b0;
		logic [7:0]                 b1;
	} enc_item_t;

	typedef struct packed {
		logic       eos;
		logic       last;
		logic [7:0] out_byte;
	} packed_byte_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // symbol[7:0], code_value[23:8], code_length[28:24]
	logic [1:0]  s_tuser;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // out_byte[7:0]
	logic        m_tlast;   // last_of_run
	logic        m_tuser;   // end_of_stream[0]

	huffman_table_encoder_bit_packer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// model state: code table and bit accumulator
	logic [hte_pkg::CODE_W-1:0] tab_code [hte_pkg::SYMBOL_COUNT_DEF];
	logic [hte_pkg::LEN_W-1:0]  tab_len  [hte_pkg::SYMBOL_COUNT_DEF];
	logic [hte_pkg::PEND_W-1:0] tail_bits;
	logic [hte_pkg::PCNT_W-1:0] tail_cnt;
	packed_byte_t               model_bytes [hte_pkg::MAX_BYTES];

	packed_byte_t               byte_q [$];   // bytes still owed by the block
	logic [hte_pkg::SYM_W-1:0]  sym_pool [$]; // symbols the generator has given codes
	enc_item_t                  dir_tab [DIR_N];
	enc_item_t                  offer;        // transaction currently on the input

	int  cyc_cnt = 0;
	int  err_cnt = 0;
	int  n_acc = 0;
	int  n_load = 0, n_enc = 0, n_flush = 0, n_bytes = 0;
	bit  quiet_tail = 0;
	bit  hold_done = 0;
	int  stall_left = 0;

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		m_tready = 1'b0;
		offer    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------
	// Model: returns the number of bytes the transaction completes and
	// leaves them in model_bytes
	// ------------------------------------------------------------------
	function automatic int pack_bits(enc_item_t it);
		logic [31:0] acc;
		logic [31:0] code;
		logic [4:0]  len;
		int          total;
		int          n;
		n = 0;
		case (it.cmd)
			hte_pkg::CMD_LOAD: begin
				len = (it.len > LEN_CAP) ? LEN_CAP : it.len;
				if (int'(it.sym) < hte_pkg::SYMBOL_COUNT_DEF) begin
					tab_code[it.sym] = it.code;
					tab_len[it.sym]  = len;
				end
			end
			hte_pkg::CMD_ENCODE: begin
				if (int'(it.sym) < hte_pkg::SYMBOL_COUNT_DEF && tab_len[it.sym] != 0) begin
					len   = tab_len[it.sym];
					code  = 32'(tab_code[it.sym]) & ((32'd1 << len) - 32'd1);
					acc   = (32'(tail_bits) << len) | code;
					total = int'(tail_cnt) + int'(len);
					while (total >= 8 && n < hte_pkg::MAX_BYTES) begin
						model_bytes[n] = '{eos: 1'b0, last: 1'b0,
							out_byte: 8'(acc >> (total - 8))};
						n++;
						total -= 8;
					end
					if (n > 0)
						model_bytes[n-1].last = 1'b1;
					tail_cnt  = hte_pkg::PCNT_W'(total);
					tail_bits = hte_pkg::PEND_W'(acc & ((32'd1 << tail_cnt) - 32'd1));
				end
			end
			hte_pkg::CMD_FLUSH: begin
				model_bytes[0] = '{eos: 1'b1, last: 1'b1,
					out_byte: 8'(32'(tail_bits) << (8 - int'(tail_cnt)))};
				n = 1;
				tail_bits = '0;
				tail_cnt  = '0;
			end
			default: ;
		endcase
		return n;
	endfunction

	// ------------------------------------------------------------------
	// Random traffic: table seeding first, then mostly encodes of known
	// symbols mixed with reloads, flushes and unused commands
	// ------------------------------------------------------------------
	function automatic enc_item_t rand_item(int idx);
		enc_item_t it;
		int        r;
		int        rl;
		it = '0;
		it.n_typed = BY_MODEL;
		it.sym  = hte_pkg::SYM_W'($urandom_range(0, 255));
		it.code = hte_pkg::CODE_W'($urandom);
		it.len  = hte_pkg::LEN_W'($urandom_range(0, 31));
		r = (idx < SEED_N) ? 0 : $urandom_range(0, 99);
		if (r < 12) begin
			it.cmd = hte_pkg::CMD_LOAD;
			if (sym_pool.size() > 0 && $urandom_range(0, 2) == 0)
				it.sym = sym_pool[$urandom_range(0, sym_pool.size() - 1)];
			rl = $urandom_range(0, 99);
			if (rl < 8)
				it.len = '0;
			else if (rl < 20)
				it.len = hte_pkg::LEN_W'($urandom_range(17, 31));
			else
				it.len = hte_pkg::LEN_W'($urandom_range(1, 16));
			if (it.len != 0 && sym_pool.size() < 48)
				sym_pool.push_back(it.sym);
		end else if (r < 78) begin
			it.cmd = hte_pkg::CMD_ENCODE;
			if (sym_pool.size() > 0 && $urandom_range(0, 99) < 85)
				it.sym = sym_pool[$urandom_range(0, sym_pool.size() - 1)];
		end else if (r < 93) begin
			it.cmd = hte_pkg::CMD_FLUSH;
		end else begin
			it.cmd = CMD_UNUSED;
		end
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Directed table: cmd, symbol, code, length, typed byte count, bytes
	// ------------------------------------------------------------------
	initial begin
		dir_tab = '{
			// empty flush right after reset gives one zero byte
			'{hte_pkg::CMD_FLUSH,  8'h00, 16'h0000,  5'd0,  1,        8'h00, 8'h00},
			// symbol never loaded
			'{hte_pkg::CMD_ENCODE, 8'h41, 16'h0000,  5'd0,  0,        8'h00, 8'h00},
			// longest code, all ones; encode fields beyond symbol are ignored
			'{hte_pkg::CMD_LOAD,   8'hFF, 16'hFFFF,  5'd16, 0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'hFF, 16'hFFFF,  5'd31, 2,        8'hFF, 8'hFF},
			// length above the maximum saturates to 16
			'{hte_pkg::CMD_LOAD,   8'h00, 16'h0000,  5'd31, 0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h00, 16'h0000,  5'd0,  2,        8'h00, 8'h00},
			// stray bits above the length are dropped
			'{hte_pkg::CMD_LOAD,   8'h01, 16'hFFFF,  5'd1,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h01, 16'h0000,  5'd0,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h01, 16'h0000,  5'd0,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h01, 16'h0000,  5'd0,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_FLUSH,  8'h00, 16'h0000,  5'd0,  1,        8'hE0, 8'h00},
			'{hte_pkg::CMD_LOAD,   8'h02, 16'hAAAA,  5'd7,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h01, 16'h0000,  5'd0,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h02, 16'h0000,  5'd0,  1,        8'hAA, 8'h00},
			// unused command with every field bit set
			'{CMD_UNUSED,          8'hFF, 16'hFFFF,  5'd31, 0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h02, 16'h0000,  5'd0,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'hFF, 16'h0000,  5'd0,  BY_MODEL, 8'h00, 8'h00},
			'{hte_pkg::CMD_FLUSH,  8'h00, 16'h0000,  5'd0,  BY_MODEL, 8'h00, 8'h00},
			'{hte_pkg::CMD_LOAD,   8'h80, 16'h8001,  5'd5,  0,        8'h00, 8'h00},
			// a load of length zero leaves the entry with no code
			'{hte_pkg::CMD_LOAD,   8'h7F, 16'h1234,  5'd0,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h80, 16'h0000,  5'd0,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h7F, 16'h0000,  5'd0,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_ENCODE, 8'h00, 16'h0000,  5'd0,  BY_MODEL, 8'h00, 8'h00},
			'{CMD_UNUSED,          8'h00, 16'h0000,  5'd0,  0,        8'h00, 8'h00},
			'{hte_pkg::CMD_FLUSH,  8'h00, 16'h0000,  5'd0,  BY_MODEL, 8'h00, 8'h00}
		};
	end

	initial begin
		for (int i = 0; i < hte_pkg::SYMBOL_COUNT_DEF; i++) begin
			tab_code[i] = '0;
			tab_len[i]  = '0;
		end
		tail_bits = '0;
		tail_cnt  = '0;
	end

	// ------------------------------------------------------------------
	// Input driver: changes at the falling edge, idles in short bursts
	// ------------------------------------------------------------------
	initial begin : feed
		enc_item_t it;
		wait (arst_n === 1'b1);
		@(negedge clk);
		for (int k = 0; k < DIR_N + RAND_N; k++) begin
			it = (k < DIR_N) ? dir_tab[k] : rand_item(k - DIR_N);
			if (k >= DIR_N + RAND_N - CALM_N)
				quiet_tail = 1'b1;
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				s_tvalid = 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			offer    = it;
			s_tuser  = it.cmd;
			s_tdata  = {3'b000, it.len, it.code, it.sym};
			s_tvalid = 1'b1;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			@(negedge clk);
		end
		s_tvalid = 1'b0;

		while (byte_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("tb: %0d loads, %0d encodes, %0d flushes accepted; %0d bytes checked",
			n_load, n_enc, n_flush, n_bytes);
		$display("tb: %0d mismatches, %0d cycles", err_cnt, cyc_cnt);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------
	// Output receiver: random short stalls, one long hold-off that backs
	// the block up into its input, none in the tail
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (!hold_done && n_acc >= DIR_N + 60) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYC - 1;
				m_tready   = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				m_tready   = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on each input transaction, checks each output one
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		packed_byte_t want;
		int           n;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				n_acc++;
				case (offer.cmd)
					hte_pkg::CMD_LOAD:   n_load++;
					hte_pkg::CMD_ENCODE: n_enc++;
					hte_pkg::CMD_FLUSH:  n_flush++;
					default: ;
				endcase
				n = pack_bits(offer);
				if (offer.n_typed != BY_MODEL) begin
					for (int i = 0; i < offer.n_typed; i++)
						byte_q.push_back('{eos: (offer.cmd == hte_pkg::CMD_FLUSH),
							last: (i == offer.n_typed - 1),
							out_byte: (i == 0) ? offer.b0 : offer.b1});
				end else begin
					for (int i = 0; i < n; i++)
						byte_q.push_back(model_bytes[i]);
				end
			end

			if (m_tvalid && m_tready) begin
				n_bytes++;
				if (byte_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("tb: unexpected byte %02h last %0d eos %0d",
							m_tdata, m_tlast, m_tuser);
				end else begin
					want = byte_q.pop_front();
					if (m_tdata !== want.out_byte || m_tlast !== want.last ||
						m_tuser !== want.eos) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("tb: byte %0d exp %02h/%0d/%0d got %02h/%0d/%0d",
								n_bytes, want.out_byte, want.last, want.eos,
								m_tdata, m_tlast, m_tuser);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cyc_cnt++;
		if (cyc_cnt > CYC_LIMIT) begin
			$display("tb: timeout, %0d bytes still owed", byte_q.size());
			$display("tb: failure");
			$finish;
		end
	end

endmodule
